>>> hw/rtl/sortpq_pkg.sv
// Shared types and codes for the sorted priority queue.
package sortpq_pkg;

    localparam int CNT_W = 4;

    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] value;
        logic signed [15:0] prio;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] out_value;
        logic signed [15:0] out_prio;
        logic [CNT_W-1:0]   count;
    } out_beat_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic latch;   // capture the accepted input beat
        logic exec;    // apply the operation and load the result register
    } sortpq_cmd_t;

endpackage

>>> hw/rtl/sortpq_ctrl.sv
// Sequencing state machine for the sorted priority queue.
module sortpq_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output sortpq_pkg::sortpq_cmd_t cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.latch      = 1'b0;
        cmd.exec       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // wait for the result register to free up
                if (out_free)
                begin
                    cmd.exec       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> hw/rtl/sortpq_dp.sv
// Datapath: sorted cell array, fill count and result register.
module sortpq_dp #(
    parameter int DEPTH = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sortpq_pkg::sortpq_cmd_t cmd,
    input  sortpq_pkg::in_beat_t    in_beat,
    output sortpq_pkg::out_beat_t   out_beat
);

    localparam int FILL_W = $clog2(DEPTH + 1);

    sortpq_pkg::in_beat_t  op_reg;
    sortpq_pkg::out_beat_t res_reg;
    logic [FILL_W-1:0]     fill_reg, fill_next;

    logic signed [31:0] val_reg  [DEPTH];
    logic signed [15:0] prio_reg [DEPTH];
    logic [DEPTH-1:0]   ge;

    logic is_full, is_empty, do_enq, do_deq;
    logic [FILL_W+sortpq_pkg::CNT_W-1:0] fill_ext;

    assign is_full  = (fill_reg == FILL_W'(DEPTH));
    assign is_empty = (fill_reg == '0);
    assign do_enq   = cmd.exec && (op_reg.mode == sortpq_pkg::MODE_ENQ) && !is_full;
    assign do_deq   = cmd.exec && (op_reg.mode == sortpq_pkg::MODE_DEQ) && !is_empty;

    // held entries with priority at or above the new one; a prefix of the array
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            ge[i] = (FILL_W'(i) < fill_reg) && (prio_reg[i] >= op_reg.prio);
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (do_enq)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_deq)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    assign fill_ext = {{sortpq_pkg::CNT_W{1'b0}}, fill_next};

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic ins_here;
            if (g == 0)
            begin : g_head
                assign ins_here = 1'b1;
            end
            else
            begin : g_body
                assign ins_here = ge[g-1];
            end

            always_ff @(posedge clk)
            begin
                if (do_enq && !ge[g])
                begin
                    if (ins_here)
                    begin
                        val_reg[g]  <= op_reg.value;
                        prio_reg[g] <= op_reg.prio;
                    end
                    else
                    begin
                        val_reg[g]  <= val_reg[(g > 0) ? g - 1 : 0];
                        prio_reg[g] <= prio_reg[(g > 0) ? g - 1 : 0];
                    end
                end
                else if (do_deq && (g < DEPTH - 1))
                begin
                    val_reg[g]  <= val_reg[(g < DEPTH - 1) ? g + 1 : g];
                    prio_reg[g] <= prio_reg[(g < DEPTH - 1) ? g + 1 : g];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg <= in_beat;
        end
        if (cmd.exec)
        begin
            res_reg.count     <= fill_ext[sortpq_pkg::CNT_W-1:0];
            res_reg.out_value <= do_deq ? val_reg[0] : 32'sd0;
            res_reg.out_prio  <= do_deq ? prio_reg[0] : 16'sd0;
            if (op_reg.mode == sortpq_pkg::MODE_ENQ)
            begin
                res_reg.status <= is_full ? sortpq_pkg::ST_FULL : sortpq_pkg::ST_DONE;
            end
            else
            begin
                res_reg.status <= is_empty ? sortpq_pkg::ST_EMPTY : sortpq_pkg::ST_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    assign out_beat = res_reg;

endmodule

>>> hw/rtl/sorted_priority_queue_core.sv
// Top level of the sorted priority queue core.
//
// Bounded priority queue of DEPTH entries kept sorted by priority, highest
// first. Each input beat is an enqueue (mode 0) or a dequeue (mode 1); each
// gives exactly one result beat with a status (done, full, empty), the
// removed value and priority on a successful dequeue (zero otherwise), and
// the entry count afterwards, reported modulo 16. Equal priorities leave in
// arrival order. Each item takes two steps, capture and execute; in execute
// every cell compares its priority with the new one in parallel and the cells
// from the insertion point on (all cells on a dequeue) shift one place. The
// result sits in an output register, so the next beat is taken while a result
// still waits; a stalled output holds execute until the register drains.
module sorted_priority_queue_core #(
    parameter int DEPTH = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sortpq_pkg::in_beat_t  in_beat,
    output logic                  out_valid,
    input  logic                  out_ready,
    output sortpq_pkg::out_beat_t out_beat
);

    sortpq_pkg::sortpq_cmd_t cmd;

    // Controller: accept, then execute once the result register is free.
    sortpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // Datapath: per-cell compare and shift, fill count, result register.
    sortpq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_beat  (in_beat),
        .out_beat (out_beat)
    );

endmodule

>>> tb/sorted_priority_queue_core_test.sv
// Self-checking testbench for the sorted priority queue core.
`timescale 1ns / 1ps

module sorted_priority_queue_core_test;

    localparam int DEPTH = 8;
    localparam int CNT_W = sortpq_pkg::CNT_W;
    // Cycles with no beat moving on either side before the run is declared hung.
    localparam int HANG_LIMIT = 500;
    // Quiet cycles allowed after the last expected result, to catch strays.
    localparam int DRAIN_CYCLES = 8;

    // Tracks the queue contents and holds the result each accepted beat should give.
    class pq_scoreboard;
        logic signed [31:0] held_value [DEPTH];
        logic signed [15:0] held_prio [DEPTH];
        int unsigned fill;
        sortpq_pkg::out_beat_t pending_results [$];
        int errors;
        int n_enq, n_deq, n_full, n_empty, n_checked;

        function new();
            fill = 0;
            errors = 0;
            n_enq = 0;
            n_deq = 0;
            n_full = 0;
            n_empty = 0;
            n_checked = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Apply one accepted input beat and queue the result it must produce.
        function void note_input(sortpq_pkg::in_beat_t b);
            sortpq_pkg::out_beat_t r;
            int pos;
            r = '0;
            r.status = sortpq_pkg::ST_DONE;
            if (b.mode == sortpq_pkg::MODE_ENQ)
            begin
                if (fill >= DEPTH)
                begin
                    r.status = sortpq_pkg::ST_FULL;
                    n_full++;
                end
                else
                begin
                    // Insert behind every entry of equal or higher priority.
                    pos = fill;
                    while (pos > 0 && $signed(held_prio[pos-1]) < $signed(b.prio))
                    begin
                        held_value[pos] = held_value[pos-1];
                        held_prio[pos] = held_prio[pos-1];
                        pos--;
                    end
                    held_value[pos] = b.value;
                    held_prio[pos] = b.prio;
                    fill++;
                    n_enq++;
                end
            end
            else
            begin
                if (fill == 0)
                begin
                    r.status = sortpq_pkg::ST_EMPTY;
                    n_empty++;
                end
                else
                begin
                    r.out_value = held_value[0];
                    r.out_prio = held_prio[0];
                    for (int i = 0; i + 1 < fill; i++)
                    begin
                        held_value[i] = held_value[i+1];
                        held_prio[i] = held_prio[i+1];
                    end
                    fill--;
                    n_deq++;
                end
            end
            r.count = CNT_W'(fill);
            pending_results.push_back(r);
        endfunction

        // Compare one accepted result beat against the oldest expectation.
        function void check_result(sortpq_pkg::out_beat_t got);
            sortpq_pkg::out_beat_t want;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result beat: status %0d value %0d prio %0d count %0d",
                       got.status, got.out_value, got.out_prio, got.count);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            n_checked++;
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.out_value !== want.out_value)
            begin
                $error("out_value: expected %0d, got %0d", want.out_value, got.out_value);
                errors++;
            end
            if (got.out_prio !== want.out_prio)
            begin
                $error("out_prio: expected %0d, got %0d", want.out_prio, got.out_prio);
                errors++;
            end
            if (got.count !== want.count)
            begin
                $error("count: expected %0d, got %0d", want.count, got.count);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    sortpq_pkg::in_beat_t  in_beat;
    logic                  out_valid;
    logic                  out_ready;
    sortpq_pkg::out_beat_t out_beat;

    // Set for the tail of the run: no gaps from the sender, no stalls from the sink.
    bit quiet;

    pq_scoreboard sb;

    sorted_priority_queue_core #(
        .DEPTH(DEPTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_beat  (in_beat),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_beat (out_beat)
    );

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Monitor: everything sampled here is the pre-edge value, so the order of
    // processes within the time step does not matter. A result can never leave
    // in the cycle its input beat is taken (output is registered).
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_input(in_beat);
            if (out_valid && out_ready)
                sb.check_result(out_beat);
        end
    end

    // Sink side: ready drops in random bursts, none once quiet is set.
    always @(posedge clk or negedge rst_n)
    begin
        int stall_left;
        if (!rst_n)
        begin
            stall_left = 0;
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 5) - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Hang detector: any cycle where neither side moves a beat counts up.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < HANG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no beat moved for %0d cycles", HANG_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // Present one input beat and hold it until taken. Optionally idle first,
    // with valid low for a random burst.
    task automatic send_beat(sortpq_pkg::in_beat_t b);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat <= b;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic enqueue(logic signed [31:0] v, logic signed [15:0] p);
        sortpq_pkg::in_beat_t b;
        b.mode = sortpq_pkg::MODE_ENQ;
        b.value = v;
        b.prio = p;
        send_beat(b);
    endtask

    // Value and priority are don't-care on a dequeue; fill them with noise.
    task automatic dequeue();
        sortpq_pkg::in_beat_t b;
        b.mode = sortpq_pkg::MODE_DEQ;
        b.value = $urandom;
        b.prio = 16'($urandom);
        send_beat(b);
    endtask

    // Stop sending and wait for every outstanding result. The first edge lets
    // the monitor record the beat that was just accepted.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Mostly a narrow band so ties are common, sometimes the extremes or anything.
    function automatic logic signed [15:0] pick_prio();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel <= 5)
            return 16'($urandom_range(0, 8) - 4);
        else if (sel == 6)
            return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        else
            return 16'($urandom);
    endfunction

    initial
    begin
        sortpq_pkg::in_beat_t b;
        int enq_pct;

        sb = new();
        quiet = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_beat = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty reject, fill to the brim with extreme values and
        // priorities plus ties, full reject, then empty it back out in order.
        dequeue();
        enqueue(32'sh7fffffff, 16'sd0);
        enqueue(32'sh80000000, 16'sh7fff);
        enqueue(32'sd0, 16'sh8000);
        enqueue(32'sd1, 16'sd0);
        enqueue(-32'sd1, 16'sd0);
        enqueue(32'sh55555555, -16'sd1);
        enqueue(32'shaaaaaaaa, 16'sd1);
        enqueue(32'sd123, 16'sh7fff);
        enqueue(32'sd9, 16'sd5);
        // Sender holds off until the queue has answered everything so far.
        drain_results();
        repeat (DEPTH) dequeue();
        dequeue();
        // Two entries tied at the lowest priority must leave in arrival order.
        enqueue(32'sd5, 16'sh8000);
        enqueue(32'sd6, 16'sh8000);
        dequeue();
        dequeue();

        // Random part: segments that lean toward filling, draining or neither,
        // so the queue keeps sweeping between empty and full.
        for (int seg = 0; seg < 16; seg++)
        begin
            case ($urandom_range(0, 2))
                0: enq_pct = 15;
                1: enq_pct = 50;
                default: enq_pct = 85;
            endcase
            if (seg == 8)
                drain_results();
            if (seg >= 14)
                quiet = 1'b1;
            for (int k = 0; k < 25; k++)
            begin
                b.mode = ($urandom_range(0, 99) < enq_pct) ? sortpq_pkg::MODE_ENQ
                                                           : sortpq_pkg::MODE_DEQ;
                b.value = $urandom;
                b.prio = pick_prio();
                send_beat(b);
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d enqueues, %0d dequeues, %0d full rejects, %0d empty rejects",
                 sb.n_enq, sb.n_deq, sb.n_full, sb.n_empty);
        $display("%0d result beats checked, %0d mismatches", sb.n_checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
